// ===== sv/jq_pkg.sv =====
`timescale 1ns / 1ps
package jq_pkg;

    typedef enum logic [2:0] {
        FN_ENQ = 3'd0,
        FN_DEQ = 3'd1,
        FN_MOD = 3'd2,
        FN_CHG = 3'd3,
        FN_PRO = 3'd4,
        FN_SRT = 3'd5,
        FN_CNT = 3'd6
    } t_func;

    typedef enum logic [2:0] {
        ST_OK       = 3'd0,
        ST_DUP      = 3'd1,
        ST_NOTFOUND = 3'd2,
        ST_EMPTY    = 3'd3,
        ST_FULL     = 3'd4,
        ST_HEAD     = 3'd5
    } t_status;

    // field select codes for change
    localparam logic [2:0] FS_PRI = 3'd1;
    localparam logic [2:0] FS_TYP = 3'd2;
    localparam logic [2:0] FS_CPU = 3'd3;
    localparam logic [2:0] FS_MEM = 3'd4;

    // sort key codes, anything else sorts by id
    localparam logic [2:0] KEY_PRI = 3'd2;
    localparam logic [2:0] KEY_TYP = 3'd3;
    localparam logic [2:0] KEY_CPU = 3'd4;
    localparam logic [2:0] KEY_MEM = 3'd5;

    typedef struct packed {
        logic [15:0] id;
        logic [7:0]  pri;
        logic [7:0]  typ;
        logic [15:0] cpu;
        logic [15:0] mem;
    } t_job;

    typedef struct packed {
        logic [2:0]  func;
        logic [15:0] job_id;
        logic [7:0]  priority_req;
        logic [7:0]  type_req;
        logic [15:0] cpu_time;
        logic [15:0] memory_used;
        logic [2:0]  field_select;
        logic [15:0] change_val;
        logic [4:0]  positions;
        logic [2:0]  sort_key;
    } t_req;

    typedef struct packed {
        logic [2:0]  status;
        logic [15:0] out_job_id;
        logic [7:0]  out_priority;
        logic [7:0]  out_type;
        logic [15:0] out_cpu_time;
        logic [15:0] out_memory;
        logic [4:0]  job_count;
    } t_res;

    typedef enum logic [1:0] {I_HOLD, I_ZERO, I_ONE, I_INC} t_iop;
    typedef enum logic [1:0] {J_HOLD, J_FROM_I, J_DEC} t_jop;
    typedef enum logic {R_I, R_JM1} t_rsel;
    typedef enum logic [2:0] {W_I, W_IM1, W_J, W_OCC, W_DST} t_wasel;
    typedef enum logic [1:0] {WD_REQ, WD_UPD, WD_RD, WD_REC} t_wdsel;
    typedef enum logic [1:0] {O_HOLD, O_INC, O_DEC} t_occop;
    typedef enum logic [1:0] {JS_NONE, JS_RD, JS_REC, JS_UPD} t_jsel;

    typedef struct packed {
        logic     latch;
        t_iop     i_op;
        t_jop     j_op;
        logic     ld_dst;
        logic     ld_rec;
        logic     re;
        t_rsel    rsel;
        logic     we;
        t_wasel   wasel;
        t_wdsel   wdsel;
        t_occop   occ_op;
        logic     res_ld;
        t_status  res_status;
        t_jsel    res_job;
    } t_dp_cmd;

    typedef struct packed {
        t_func func;
        logic  i_eq_occ;
        logic  i_zero;
        logic  occ_zero;
        logic  occ_le1;
        logic  occ_full;
        logic  found;
        logic  j_eq_dst;
        logic  j_zero;
        logic  after;
    } t_dp_stat;

    typedef enum logic [3:0] {
        S_IDLE, S_DISP, S_LOC_RD, S_LOC_CMP, S_PR_RD, S_PR_WR,
        S_DQ_RD0, S_DQ_HEAD, S_DQ_RD, S_DQ_WR,
        S_SO_KEY, S_SO_KEYW, S_SO_RD, S_SO_CMP, S_OUT
    } t_state;

    function automatic logic [15:0] key_of(t_job r, logic [2:0] k);
        logic [15:0] v;
        unique case (k)
            KEY_PRI: v = {8'd0, r.pri};
            KEY_TYP: v = {8'd0, r.typ};
            KEY_CPU: v = r.cpu;
            KEY_MEM: v = r.mem;
            default: v = r.id;
        endcase
        return v;
    endfunction

    function automatic logic sorts_after(t_job a, t_job b, logic [2:0] k);
        logic [15:0] ka;
        logic [15:0] kb;
        ka = key_of(a, k);
        kb = key_of(b, k);
        if (ka != kb) begin
            return ka > kb;
        end
        return a.id > b.id;
    endfunction

endpackage

// ===== sv/jq_req_if.sv =====
`timescale 1ns / 1ps
interface jq_req_if;
    logic          valid;
    logic          ready;
    jq_pkg::t_req  payload;
    modport source(output valid, output payload, input ready);
    modport sink(input valid, input payload, output ready);
endinterface

// ===== sv/jq_res_if.sv =====
`timescale 1ns / 1ps
interface jq_res_if;
    logic          valid;
    logic          ready;
    jq_pkg::t_res  payload;
    modport source(output valid, output payload, input ready);
    modport sink(input valid, input payload, output ready);
endinterface

// ===== sv/jq_dp.sv =====
`timescale 1ns / 1ps
module jq_dp #(
    parameter int DEPTH = 16
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  jq_pkg::t_req      i_req,
    input  jq_pkg::t_dp_cmd   i_cmd,
    output jq_pkg::t_dp_stat  o_stat,
    output jq_pkg::t_res      o_res
);
    import jq_pkg::*;

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam int XW = (CW > 5) ? CW : 5;

    t_job          r_mem [DEPTH];
    t_job          r_rd;
    t_job          r_rec;
    t_req          r_req;
    logic [CW-1:0] r_occ;
    logic [CW-1:0] r_i;
    logic [CW-1:0] r_j;
    logic [CW-1:0] r_dst;
    t_status       r_res_status;
    t_job          r_res_job;

    logic [CW-1:0] jm1;
    logic [CW-1:0] im1;
    logic [CW-1:0] n_dst;
    logic [XW-1:0] pos_x;
    logic [XW-1:0] i_x;
    logic [AW-1:0] raddr;
    logic [AW-1:0] waddr;
    t_job          wdata;
    t_job          upd;
    t_job          req_job;
    logic [7:0]    sat;

    assign jm1 = r_j - CW'(1);
    assign im1 = r_i - CW'(1);
    assign pos_x = XW'(r_req.positions);
    assign i_x = XW'(r_i);
    assign n_dst = (pos_x >= i_x) ? '0 : CW'(i_x - pos_x);
    assign sat = (r_req.change_val > 16'd255) ? 8'd255 : r_req.change_val[7:0];
    assign req_job = '{id: r_req.job_id, pri: r_req.priority_req, typ: r_req.type_req,
                       cpu: r_req.cpu_time, mem: r_req.memory_used};

    // updated record for modify and change
    always_comb begin
        upd = r_rd;
        if (t_func'(r_req.func) == FN_MOD) begin
            upd = '{id: r_rd.id, pri: r_req.priority_req, typ: r_req.type_req,
                    cpu: r_req.cpu_time, mem: r_req.memory_used};
        end else begin
            unique case (r_req.field_select)
                FS_PRI:  upd.pri = sat;
                FS_TYP:  upd.typ = sat;
                FS_CPU:  upd.cpu = r_req.change_val;
                FS_MEM:  upd.mem = r_req.change_val;
                default: upd = r_rd;
            endcase
        end
    end

    always_comb begin
        unique case (i_cmd.rsel)
            R_I:     raddr = r_i[AW-1:0];
            R_JM1:   raddr = jm1[AW-1:0];
            default: raddr = r_i[AW-1:0];
        endcase
        unique case (i_cmd.wasel)
            W_I:     waddr = r_i[AW-1:0];
            W_IM1:   waddr = im1[AW-1:0];
            W_J:     waddr = r_j[AW-1:0];
            W_OCC:   waddr = r_occ[AW-1:0];
            W_DST:   waddr = r_dst[AW-1:0];
            default: waddr = r_i[AW-1:0];
        endcase
        unique case (i_cmd.wdsel)
            WD_REQ:  wdata = req_job;
            WD_UPD:  wdata = upd;
            WD_RD:   wdata = r_rd;
            WD_REC:  wdata = r_rec;
            default: wdata = r_rd;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.we) begin
            r_mem[waddr] <= wdata;
        end
        if (i_cmd.re) begin
            r_rd <= r_mem[raddr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_occ <= '0;
        end else begin
            unique case (i_cmd.occ_op)
                O_INC:   r_occ <= r_occ + CW'(1);
                O_DEC:   r_occ <= r_occ - CW'(1);
                default: r_occ <= r_occ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.latch) begin
            r_req <= i_req;
        end
        unique case (i_cmd.i_op)
            I_ZERO:  r_i <= '0;
            I_ONE:   r_i <= CW'(1);
            I_INC:   r_i <= r_i + CW'(1);
            default: r_i <= r_i;
        endcase
        unique case (i_cmd.j_op)
            J_FROM_I: r_j <= r_i;
            J_DEC:    r_j <= jm1;
            default:  r_j <= r_j;
        endcase
        if (i_cmd.ld_dst) begin
            r_dst <= n_dst;
        end
        if (i_cmd.ld_rec) begin
            r_rec <= r_rd;
        end
        if (i_cmd.res_ld) begin
            r_res_status <= i_cmd.res_status;
            unique case (i_cmd.res_job)
                JS_RD:   r_res_job <= r_rd;
                JS_REC:  r_res_job <= r_rec;
                JS_UPD:  r_res_job <= upd;
                default: r_res_job <= '0;
            endcase
        end
    end

    always_comb begin
        o_stat.func     = t_func'(r_req.func);
        o_stat.i_eq_occ = (r_i == r_occ);
        o_stat.i_zero   = (r_i == '0);
        o_stat.occ_zero = (r_occ == '0);
        o_stat.occ_le1  = (r_occ <= CW'(1));
        o_stat.occ_full = (r_occ == CW'(DEPTH));
        o_stat.found    = (r_rd.id == r_req.job_id);
        o_stat.j_eq_dst = (r_j == r_dst);
        o_stat.j_zero   = (r_j == '0);
        o_stat.after    = sorts_after(r_rd, r_rec, r_req.sort_key);
    end

    assign o_res.status       = r_res_status;
    assign o_res.out_job_id   = r_res_job.id;
    assign o_res.out_priority = r_res_job.pri;
    assign o_res.out_type     = r_res_job.typ;
    assign o_res.out_cpu_time = r_res_job.cpu;
    assign o_res.out_memory   = r_res_job.mem;
    assign o_res.job_count    = 5'(r_occ);

`ifndef SYNTH
    a_occ_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_occ <= CW'(DEPTH)) else $error("occupancy above depth");
    a_no_push_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.we && i_cmd.wasel == W_OCC |-> r_occ < CW'(DEPTH))
        else $error("tail write into full queue");
    a_no_pop_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.occ_op == O_DEC |-> r_occ != '0) else $error("pop from empty queue");
    a_occ_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.occ_op == O_INC |=> r_occ == $past(r_occ) + CW'(1))
        else $error("occupancy did not advance");
`endif

endmodule

// ===== sv/jq_ctrl.sv =====
`timescale 1ns / 1ps
module jq_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    input  jq_pkg::t_dp_stat  i_stat,
    output jq_pkg::t_dp_cmd   o_cmd
);
    import jq_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd = '{latch: 1'b0, i_op: I_HOLD, j_op: J_HOLD, ld_dst: 1'b0, ld_rec: 1'b0,
                  re: 1'b0, rsel: R_I, we: 1'b0, wasel: W_I, wdsel: WD_RD,
                  occ_op: O_HOLD, res_ld: 1'b0, res_status: ST_OK, res_job: JS_NONE};
        o_in_ready = 1'b0;
        o_out_valid = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.latch = 1'b1;
                    n_state = S_DISP;
                end
            end
            S_DISP: begin
                o_cmd.res_ld = 1'b1;
                unique case (i_stat.func)
                    FN_ENQ, FN_MOD, FN_CHG, FN_PRO: begin
                        o_cmd.res_ld = 1'b0;
                        o_cmd.i_op = I_ZERO;
                        n_state = S_LOC_RD;
                    end
                    FN_DEQ: begin
                        if (i_stat.occ_zero) begin
                            o_cmd.res_status = ST_EMPTY;
                            n_state = S_OUT;
                        end else begin
                            o_cmd.res_ld = 1'b0;
                            o_cmd.i_op = I_ZERO;
                            n_state = S_DQ_RD0;
                        end
                    end
                    FN_SRT: begin
                        if (i_stat.occ_le1) begin
                            n_state = S_OUT;
                        end else begin
                            o_cmd.i_op = I_ONE;
                            n_state = S_SO_KEY;
                        end
                    end
                    default: n_state = S_OUT;
                endcase
            end
            S_LOC_RD: begin
                if (i_stat.i_eq_occ) begin
                    o_cmd.res_ld = 1'b1;
                    n_state = S_OUT;
                    if (i_stat.func == FN_ENQ) begin
                        if (i_stat.occ_full) begin
                            o_cmd.res_status = ST_FULL;
                        end else begin
                            o_cmd.we = 1'b1;
                            o_cmd.wasel = W_OCC;
                            o_cmd.wdsel = WD_REQ;
                            o_cmd.occ_op = O_INC;
                        end
                    end else begin
                        o_cmd.res_status = ST_NOTFOUND;
                    end
                end else begin
                    o_cmd.re = 1'b1;
                    o_cmd.rsel = R_I;
                    n_state = S_LOC_CMP;
                end
            end
            S_LOC_CMP: begin
                if (!i_stat.found) begin
                    o_cmd.i_op = I_INC;
                    n_state = S_LOC_RD;
                end else begin
                    priority case (i_stat.func)
                        FN_ENQ: begin
                            o_cmd.res_ld = 1'b1;
                            o_cmd.res_status = ST_DUP;
                            n_state = S_OUT;
                        end
                        FN_MOD, FN_CHG: begin
                            o_cmd.we = 1'b1;
                            o_cmd.wasel = W_I;
                            o_cmd.wdsel = WD_UPD;
                            o_cmd.res_ld = 1'b1;
                            o_cmd.res_job = JS_UPD;
                            n_state = S_OUT;
                        end
                        FN_PRO: begin
                            if (i_stat.i_zero) begin
                                o_cmd.res_ld = 1'b1;
                                o_cmd.res_status = ST_HEAD;
                                n_state = S_OUT;
                            end else begin
                                o_cmd.ld_rec = 1'b1;
                                o_cmd.ld_dst = 1'b1;
                                o_cmd.j_op = J_FROM_I;
                                n_state = S_PR_RD;
                            end
                        end
                        default: begin
                            o_cmd.res_ld = 1'b1;
                            n_state = S_OUT;
                        end
                    endcase
                end
            end
            S_PR_RD: begin
                if (i_stat.j_eq_dst) begin
                    o_cmd.we = 1'b1;
                    o_cmd.wasel = W_DST;
                    o_cmd.wdsel = WD_REC;
                    o_cmd.res_ld = 1'b1;
                    o_cmd.res_job = JS_REC;
                    n_state = S_OUT;
                end else begin
                    o_cmd.re = 1'b1;
                    o_cmd.rsel = R_JM1;
                    n_state = S_PR_WR;
                end
            end
            S_PR_WR: begin
                o_cmd.we = 1'b1;
                o_cmd.wasel = W_J;
                o_cmd.wdsel = WD_RD;
                o_cmd.j_op = J_DEC;
                n_state = S_PR_RD;
            end
            S_DQ_RD0: begin
                o_cmd.re = 1'b1;
                o_cmd.rsel = R_I;
                o_cmd.i_op = I_ONE;
                n_state = S_DQ_HEAD;
            end
            S_DQ_HEAD: begin
                o_cmd.res_ld = 1'b1;
                o_cmd.res_job = JS_RD;
                n_state = S_DQ_RD;
            end
            S_DQ_RD: begin
                if (i_stat.i_eq_occ) begin
                    o_cmd.occ_op = O_DEC;
                    n_state = S_OUT;
                end else begin
                    o_cmd.re = 1'b1;
                    o_cmd.rsel = R_I;
                    n_state = S_DQ_WR;
                end
            end
            S_DQ_WR: begin
                o_cmd.we = 1'b1;
                o_cmd.wasel = W_IM1;
                o_cmd.wdsel = WD_RD;
                o_cmd.i_op = I_INC;
                n_state = S_DQ_RD;
            end
            S_SO_KEY: begin
                if (i_stat.i_eq_occ) begin
                    n_state = S_OUT;
                end else begin
                    o_cmd.re = 1'b1;
                    o_cmd.rsel = R_I;
                    n_state = S_SO_KEYW;
                end
            end
            S_SO_KEYW: begin
                o_cmd.ld_rec = 1'b1;
                o_cmd.j_op = J_FROM_I;
                n_state = S_SO_RD;
            end
            S_SO_RD: begin
                if (i_stat.j_zero) begin
                    o_cmd.we = 1'b1;
                    o_cmd.wasel = W_J;
                    o_cmd.wdsel = WD_REC;
                    o_cmd.i_op = I_INC;
                    n_state = S_SO_KEY;
                end else begin
                    o_cmd.re = 1'b1;
                    o_cmd.rsel = R_JM1;
                    n_state = S_SO_CMP;
                end
            end
            S_SO_CMP: begin
                o_cmd.we = 1'b1;
                o_cmd.wasel = W_J;
                if (i_stat.after) begin
                    o_cmd.wdsel = WD_RD;
                    o_cmd.j_op = J_DEC;
                    n_state = S_SO_RD;
                end else begin
                    o_cmd.wdsel = WD_REC;
                    o_cmd.i_op = I_INC;
                    n_state = S_SO_KEY;
                end
            end
            S_OUT: begin
                o_out_valid = 1'b1;
                if (i_out_ready) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

endmodule

// ===== sv/job_queue_with_id_lookup.sv =====
`timescale 1ns / 1ps
// job queue with lookup by id
// i_req carries one command item (func plus operands), o_res returns exactly
// one result item per command: status, the affected job and the job count.
// jobs sit in a single-port-write, registered-read slot memory, head at slot 0.
// one command is in flight at a time: i_req.ready is high only while idle, and
// a finished result is held in o_res until the receiver takes it; a stalled
// receiver simply holds the block in its output state.
// work per command, with n jobs held and k the slot of a found job:
//   count, reorder of n <= 1, unused codes, empty dequeue: no slot walk
//   enqueue, modify, change: walk slots 0 to k, or all n slots if absent
//   promote from slot k by m places: the jobs it passes shift back (head: none)
//   dequeue: memory shift of the whole queue
//   reorder: insertion sort
// the slot walk reads the memory one slot at a time.
// reset clears the state machine and the job count; slot contents need no
// clearing since slots beyond the count are never read.
module job_queue_with_id_lookup #(
    parameter int QUEUE_DEPTH = 16
) (
    input  logic  i_clk,
    input  logic  i_rst_n,
    jq_req_if.sink    i_req,
    jq_res_if.source  o_res
);
    import jq_pkg::*;

    // command and status between sequencer and slot datapath
    t_dp_cmd  dp_cmd;
    t_dp_stat dp_stat;

    jq_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_req.valid),
        .o_in_ready  (i_req.ready),
        .o_out_valid (o_res.valid),
        .i_out_ready (o_res.ready),
        .i_stat      (dp_stat),
        .o_cmd       (dp_cmd)
    );

    // slot memory, counters and result register
    jq_dp #(
        .DEPTH (QUEUE_DEPTH)
    ) u_dp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (i_req.payload),
        .i_cmd   (dp_cmd),
        .o_stat  (dp_stat),
        .o_res   (o_res.payload)
    );

`ifndef SYNTH
    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_req.valid && i_req.ready |=> !i_req.ready)
        else $error("second item taken while busy");
    a_no_take_while_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res.valid |-> !i_req.ready) else $error("input open with result pending");
    a_result_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res.valid && o_res.ready |=> i_req.ready)
        else $error("not idle after result taken");
`endif

endmodule
